@@ rtl/sbpf_pkg.sv @@
package sbpf_pkg;

   // packet constants
   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [7:0]  SYNC_TAIL     = 8'hFD;
   localparam logic [7:0]  INSTR_WRITE   = 8'h03;
   localparam logic [7:0]  INSTR_READ    = 8'h02;
   localparam logic [15:0] CRC_POLY      = 16'h8005;
   localparam logic [15:0] CRC_MSB       = 16'h8000;
   localparam int          MAX_WRITE_BYTES = 4;

   // fixed header bytes counted by the length field: instruction, address, crc
   localparam int          LEN_FIXED     = 5;

   localparam int          STEP_W        = 4;
   localparam int          IDX_W         = 2;

   typedef enum logic [3:0] {
      SRC_SYNC,
      SRC_TAIL,
      SRC_ZERO,
      SRC_ID,
      SRC_LEN,
      SRC_INSTR,
      SRC_ADDR_LO,
      SRC_ADDR_HI,
      SRC_DATA,
      SRC_CRC_LO,
      SRC_CRC_HI
   } src_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_LOOP,
      COND_END
   } cond_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      src_type             src;
      logic                feed;
      logic                last;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   // sequencer to datapath control
   typedef struct packed {
      logic                load;
      logic                emit;
      src_type             src;
      logic                feed;
      logic                last;
      logic [IDX_W-1:0]    data_idx;
   } dp_ctl_type;

   // microcode program, one word per packet byte, the data bytes sharing one looped word
   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{src: SRC_ZERO, feed: 1'b0, last: 1'b0, cond: COND_END, target: '0};
      unique case (step)
         4'd0:  w = '{SRC_SYNC,    1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd1:  w = '{SRC_SYNC,    1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd2:  w = '{SRC_TAIL,    1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd3:  w = '{SRC_ZERO,    1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd4:  w = '{SRC_ID,      1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd5:  w = '{SRC_LEN,     1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd6:  w = '{SRC_ZERO,    1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd7:  w = '{SRC_INSTR,   1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd8:  w = '{SRC_ADDR_LO, 1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd9:  w = '{SRC_ADDR_HI, 1'b1, 1'b0, COND_NEXT, 4'd0};
         4'd10: w = '{SRC_DATA,    1'b1, 1'b0, COND_LOOP, 4'd10};
         4'd11: w = '{SRC_CRC_LO,  1'b0, 1'b0, COND_NEXT, 4'd0};
         4'd12: w = '{SRC_CRC_HI,  1'b0, 1'b1, COND_END,  4'd0};
         default: w = '{SRC_ZERO,  1'b0, 1'b1, COND_END,  4'd0};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/servo_bus_packet_framer_core.sv @@
// first byte: after the request load, the sequencer emits it into the output register
// throughput: one byte per cycle unless rsp_ready stalls, 13..16 bytes per packet
//   (write 12 + data count, read 14); the next request is taken only after the last
//   byte, once the sequencer is idle; a single microcode step counter steps each packet
// reset: synchronous active high; clears sequencer, crc and output valid
module servo_bus_packet_framer_core import sbpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_reg_address,
   input  logic [31:0] req_write_value,
   input  logic [2:0]  req_write_bytes,
   input  logic [15:0] req_read_length,
   // response channel, one transaction per packet byte
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   dp_ctl_type ctl;
   logic       slot_free;
   logic       data_done;
   logic [7:0] byte_next;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   // output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // microcode sequencer: step counter, program rom, data loop
   sbpf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .slot_free (slot_free),
      .data_done (data_done),
      .ctl       (ctl)
   );

   // datapath: held request, byte select, crc accumulator
   sbpf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_opcode      (req_opcode),
      .req_servo_id    (req_servo_id),
      .req_reg_address (req_reg_address),
      .req_write_value (req_write_value),
      .req_write_bytes (req_write_bytes),
      .req_read_length (req_read_length),
      .byte_out        (byte_next),
      .data_done       (data_done)
   );

   // output valid tracks emitted bytes against downstream take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, loaded with each emitted byte
   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_byte_ff <= byte_next;
         rsp_last_ff <= ctl.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

@@ rtl/sbpf_seq.sv @@
module sbpf_seq import sbpf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       slot_free,
   input  logic       data_done,
   output dp_ctl_type ctl
);

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   ucode_type         word;
   logic              load;
   logic              advance;

   assign word    = ucode_word(step_ff);
   assign load    = req_valid && (state_ff == SEQ_IDLE);
   assign advance = (state_ff == SEQ_RUN) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) state_in = SEQ_RUN;
         end
         SEQ_RUN: begin
            if (advance && word.cond == COND_END) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == SEQ_IDLE);
      ctl.load     = load;
      ctl.emit     = advance;
      ctl.src      = word.src;
      ctl.feed     = word.feed;
      ctl.last     = word.last;
      ctl.data_idx = idx_ff;
   end

   // step counter with conditional jumps
   always_comb begin
      step_in = step_ff;
      idx_in  = idx_ff;
      if (load) begin
         step_in = '0;
         idx_in  = '0;
      end else if (advance) begin
         priority case (word.cond)
            COND_LOOP: begin
               if (data_done) begin
                  step_in = step_ff + 1'b1;
               end else begin
                  step_in = word.target;
                  idx_in  = idx_ff + 1'b1;
               end
            end
            COND_END: step_in = '0;
            default:  step_in = step_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
      end
   end

   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && word.last) |=> (state_ff == SEQ_IDLE && step_ff == '0))
      else $error("packet end did not return to idle");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN && !slot_free) |=> ($stable(step_ff) && $stable(idx_ff)))
      else $error("step moved while output stalled");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == SEQ_RUN && step_ff == '0 && idx_ff == '0))
      else $error("load did not start the program");

   a_idx_only_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN && word.src != SRC_DATA && step_ff != '0 &&
       word.src != SRC_CRC_LO && word.src != SRC_CRC_HI) |-> (idx_ff == '0))
      else $error("data index moved outside the data loop");

endmodule

@@ rtl/sbpf_dp.sv @@
module sbpf_dp import sbpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_ctl_type  ctl,
   input  logic        req_opcode,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_reg_address,
   input  logic [31:0] req_write_value,
   input  logic [2:0]  req_write_bytes,
   input  logic [15:0] req_read_length,
   output logic [7:0]  byte_out,
   output logic        data_done
);

   logic [7:0]       id_ff;
   logic [15:0]      addr_ff;
   logic [31:0]      payload_ff;
   logic             read_ff;
   logic [IDX_W-1:0] cnt_m1_ff, cnt_m1_in;
   logic [15:0]      crc_ff, crc_in;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) c = (c << 1) ^ CRC_POLY;
         else                          c = c << 1;
      end
      return c;
   endfunction

   // clamp write count to 1..MAX_WRITE_BYTES, stored minus one; reads store a count of two
   always_comb begin
      if (req_opcode) begin
         cnt_m1_in = IDX_W'(1);
      end else if (req_write_bytes == 3'd0) begin
         cnt_m1_in = '0;
      end else if (req_write_bytes > 3'(MAX_WRITE_BYTES)) begin
         cnt_m1_in = IDX_W'(MAX_WRITE_BYTES - 1);
      end else begin
         cnt_m1_in = IDX_W'(req_write_bytes - 3'd1);
      end
   end

   always_comb begin
      unique case (ctl.src)
         SRC_SYNC:    byte_out = SYNC_BYTE;
         SRC_TAIL:    byte_out = SYNC_TAIL;
         SRC_ZERO:    byte_out = 8'h00;
         SRC_ID:      byte_out = id_ff;
         SRC_LEN:     byte_out = 8'(LEN_FIXED + 1) + {6'b0, cnt_m1_ff};
         SRC_INSTR:   byte_out = read_ff ? INSTR_READ : INSTR_WRITE;
         SRC_ADDR_LO: byte_out = addr_ff[7:0];
         SRC_ADDR_HI: byte_out = addr_ff[15:8];
         SRC_DATA:    byte_out = 8'(payload_ff >> {ctl.data_idx, 3'b000});
         SRC_CRC_LO:  byte_out = crc_ff[7:0];
         SRC_CRC_HI:  byte_out = crc_ff[15:8];
         default:     byte_out = 8'h00;
      endcase
   end

   assign data_done = (ctl.data_idx == cnt_m1_ff);

   always_comb begin
      crc_in = crc_ff;
      if (ctl.load)                  crc_in = '0;
      else if (ctl.emit && ctl.feed) crc_in = crc_feed(crc_ff, byte_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   // request hold registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         id_ff      <= req_servo_id;
         addr_ff    <= req_reg_address;
         payload_ff <= req_opcode ? {16'h0000, req_read_length} : req_write_value;
         read_ff    <= req_opcode;
         cnt_m1_ff  <= cnt_m1_in;
      end
   end

endmodule
